FILE: design/pstf_pkg.sv
// Shared constants and types for the PCM sample to float converter.
// No dependencies.
`default_nettype none
package pstf_pkg;
	localparam int SampleWidth = 64;
	localparam int FloatWidth  = 32;
	localparam int FmtWidth    = 4;

	typedef enum logic [FmtWidth-1:0] {
		FMT_U8  = 4'd0,
		FMT_U16 = 4'd1,
		FMT_U24 = 4'd2,
		FMT_U32 = 4'd3,
		FMT_S8  = 4'd4,
		FMT_S16 = 4'd5,
		FMT_S24 = 4'd6,
		FMT_S32 = 4'd7,
		FMT_F32 = 4'd8,
		FMT_F64 = 4'd9
	} fmt_t;

	localparam logic [FloatWidth-1:0] FloatInf  = 32'h7F80_0000;
	localparam logic [FloatWidth-1:0] FloatQnan = 32'h7FC0_0000;
endpackage
`default_nettype wire

FILE: design/pstf_int_conv.sv
// Integer sample to normalized float32 conversion, single combinational pass.
// No dependencies.
`default_nettype none
module pstf_int_conv (
	input  wire logic [3:0]  fmt,
	input  wire logic [31:0] word,
	output logic [31:0]      result
);
	logic        signed_fmt;
	logic [5:0]  bits;
	logic [31:0] raw;
	logic [32:0] val;
	logic        sgn;
	logic [31:0] mag;
	logic [4:0]  lz;
	logic [31:0] norm;
	logic [23:0] q;
	logic        rnd;
	logic        sticky;
	logic [24:0] qr;
	logic [7:0]  expo;

	// Round to 24 significant bits, nearest-even; the value stays an integer.
	function automatic logic [32:0] round_to_24(input logic [31:0] x);
		logic [4:0]  n;
		logic [31:0] nx;
		logic [24:0] r;
		n = 5'd0;
		for (int i = 0; i < 32; i++)
			if (x[i]) n = 5'(31 - i);
		nx = x << n;
		r = {1'b0, nx[31:8]} + 25'(nx[7] && ((|nx[6:0]) || nx[8]));
		return {r, 8'd0} >> n;
	endfunction

	// Unsigned samples round to float first, then the offset difference rounds
	// again; signed samples round once. The power-of-two scale only moves the
	// exponent.
	always_comb begin
		signed_fmt = fmt[2];
		unique case (fmt[1:0])
			2'd0: bits = 6'd8;
			2'd1: bits = 6'd16;
			2'd2: bits = 6'd24;
			default: bits = 6'd32;
		endcase
		unique case (fmt[1:0])
			2'd0: raw = {24'd0, word[7:0]};
			2'd1: raw = {16'd0, word[15:0]};
			2'd2: raw = {8'd0, word[23:0]};
			default: raw = word;
		endcase
		unique case (fmt[1:0])
			2'd0: val = {{25{word[7]}}, word[7:0]};
			2'd1: val = {{17{word[15]}}, word[15:0]};
			2'd2: val = {{9{word[23]}}, word[23:0]};
			default: val = {word[31], word};
		endcase
		if (!signed_fmt)
			val = round_to_24(raw) - (33'd1 << (bits - 6'd1));
		sgn = val[32];
		mag = sgn ? 32'(-val) : val[31:0];
		lz = 5'd0;
		for (int i = 0; i < 32; i++)
			if (mag[i]) lz = 5'(31 - i);
		norm = mag << lz;
		q = norm[31:8];
		rnd = norm[7];
		sticky = |norm[6:0];
		qr = {1'b0, q} + 25'(rnd && (sticky || q[0]));
		// value = mag * 2^-(bits-1); msb at 31-lz
		expo = 8'(127 + 31 - 32'(lz) - 32'(bits) + 1);
		if (qr[24]) expo = expo + 8'd1;
		if (mag == 32'd0)
			result = 32'd0;
		else
			result = {sgn, expo, qr[24] ? qr[23:1] : qr[22:0]};
	end
endmodule
`default_nettype wire

FILE: design/pstf_f64_narrow.sv
// Float64 to float32 narrowing with round-to-nearest-even.
// Depends on pstf_pkg.
`default_nettype none
module pstf_f64_narrow (
	input  wire logic [63:0] word,
	output logic [31:0]      result
);
	logic        sgn;
	logic [10:0] e;
	logic [51:0] mant;
	logic signed [12:0] fe;
	logic [9:0]  sh;
	logic [52:0] m;
	logic [52:0] q;
	logic [52:0] rem;
	logic [52:0] half;
	logic [52:0] mask;
	logic [31:0] base;
	logic [31:0] sum;

	always_comb begin
		sgn  = word[63];
		e    = word[62:52];
		mant = word[51:0];
		fe   = 13'(e) - 13'sd896;
		m    = {1'b1, mant};
		sh   = (fe >= 13'sd1) ? 10'd29 : 10'(13'sd30 - fe);
		base = (fe >= 13'sd1) ? {1'b0, fe[7:0] - 8'd1, 23'd0} : 32'd0;
		q    = m >> sh;
		mask = (53'd1 << sh) - 53'd1;
		rem  = m & mask;
		half = 53'd1 << (sh - 10'd1);
		if (rem > half || (rem == half && q[0]))
			q = q + 53'd1;
		sum = base + q[31:0];
		if (sum >= pstf_pkg::FloatInf) sum = pstf_pkg::FloatInf;
		if (e == 11'h7FF) begin
			if (mant == 52'd0) result = {sgn, pstf_pkg::FloatInf[30:0]};
			else result = {sgn, pstf_pkg::FloatQnan[30:0] | {9'd0, mant[50:29]}};
		end else if (e == 11'd0) begin
			result = {sgn, 31'd0};
		end else if (fe >= 13'sd255) begin
			result = {sgn, pstf_pkg::FloatInf[30:0]};
		end else if (sh >= 10'd54) begin
			result = {sgn, 31'd0};
		end else begin
			result = {sgn, sum[30:0]};
		end
	end
endmodule
`default_nettype wire

FILE: design/pcm_sample_to_float.sv
// PCM sample to float32 converter: one sample word per beat, one result
// beat per sample, held in a single result register.
// A new sample is taken every cycle while the output is not stalled, or
// while the result register is empty. The format register, loaded from
// cfg_data when cfg_we is high, selects the rule. Depends on pstf_pkg, pstf_int_conv, pstf_f64_narrow.
`default_nettype none
module pcm_sample_to_float (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] sample_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      float_bits
);
	logic [3:0]  fmt_q;
	logic [31:0] int_res;
	logic [31:0] dbl_res;
	logic [31:0] next_res;
	logic        valid_s1;
	logic [31:0] res_s1;

	pstf_int_conv u_int (.fmt(fmt_q), .word(sample_word[31:0]), .result(int_res));
	pstf_f64_narrow u_dbl (.word(sample_word), .result(dbl_res));

	always_comb begin
		priority if (fmt_q <= pstf_pkg::FMT_S32) next_res = int_res;
		else if (fmt_q == pstf_pkg::FMT_F32) next_res = sample_word[31:0];
		else if (fmt_q == pstf_pkg::FMT_F64) next_res = dbl_res;
		else next_res = 32'd0;
	end

	assign in_stall   = valid_s1 && out_stall;
	assign out_valid  = valid_s1;
	assign float_bits = res_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= 4'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) fmt_q <= cfg_data;
			if (!in_stall) valid_s1 <= in_valid;
		end
	end

	// Load the result register whenever it is free and the input sample is valid.
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) res_s1 <= next_res;
	end
endmodule
`default_nettype wire
